// ----- rtl/escaped_frame_decoder_defines.svh -----
// Assertion macros shared by the escaped frame decoder RTL.
`ifndef ESCAPED_FRAME_DECODER_DEFINES_SVH
`define ESCAPED_FRAME_DECODER_DEFINES_SVH

// Checked on every rising clk edge outside reset.
`define EFD_ASSERT_RUN(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define EFD_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/efd_pkg.sv -----
// Types and constants shared by the escaped frame decoder modules.
package efd_pkg;

	// Escape sequence bytes
	localparam logic [7:0] ESC_BYTE = 8'd61;
	localparam logic [7:0] CODE_60  = 8'd44;
	localparam logic [7:0] CODE_61  = 8'd45;
	localparam logic [7:0] CODE_62  = 8'd46;
	localparam logic [7:0] DEC_60   = 8'd60;
	localparam logic [7:0] DEC_61   = 8'd61;
	localparam logic [7:0] DEC_62   = 8'd62;

	// Message layout
	localparam int unsigned CNT_W = 34;
	localparam logic [CNT_W-1:0] HEADER_LEN = CNT_W'(6);
	localparam logic [CNT_W-1:0] MIN_LEN    = CNT_W'(7);
	localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

	// Header byte positions
	localparam logic [CNT_W-1:0] POS_TYPE = CNT_W'(0);
	localparam logic [CNT_W-1:0] POS_SEQ  = CNT_W'(1);

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_ESC_END       = 3'd1,
		ST_BAD_ESC       = 3'd2,
		ST_SHORT         = 3'd3,
		ST_PAYLOAD_SHORT = 3'd4,
		ST_CHECKSUM      = 3'd5
	} efd_status_t;

	// One result item plus its valid flag
	typedef struct packed {
		logic        valid;
		logic        is_status;
		logic [7:0]  payload_byte;
		logic [7:0]  msg_type;
		logic [7:0]  msg_seq;
		logic [31:0] declared_size;
		efd_status_t status;
		logic        last;
	} efd_result_t;

endpackage

// ----- rtl/efd_core.sv -----
// Unescaping, header capture, checksum and status logic for one byte per cycle while step is high.
module efd_core import efd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_s1,
	input  logic        last_s1,
	output efd_result_t res
);

	logic             esc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       type_q;
	logic [7:0]       seq_q;
	logic [31:0]      size_q;
	logic [7:0]       sum_q;
	efd_status_t      err_q;

	logic             esc_d;
	logic [CNT_W-1:0] cnt_d;
	logic [7:0]       type_d;
	logic [7:0]       seq_d;
	logic [31:0]      size_d;
	logic [7:0]       sum_d;
	efd_status_t      err_d;
	efd_status_t      err_new;
	efd_status_t      end_st;
	logic             have;
	logic [7:0]       val;
	logic             in_payload;
	logic             sum_ok;

	// Unescape, update message state, build the result
	always_comb begin
		have    = 1'b0;
		val     = 8'd0;
		esc_d   = 1'b0;
		err_new = ST_OK;
		if (esc_q) begin
			case (byte_s1)
				CODE_60: begin
					val  = DEC_60;
					have = 1'b1;
				end
				CODE_61: begin
					val  = DEC_61;
					have = 1'b1;
				end
				CODE_62: begin
					val  = DEC_62;
					have = 1'b1;
				end
				default: err_new = ST_BAD_ESC;
			endcase
		end else if (byte_s1 == ESC_BYTE) begin
			if (last_s1)
				err_new = ST_ESC_END;
			else
				esc_d = 1'b1;
		end else begin
			val  = byte_s1;
			have = 1'b1;
		end

		// first error is kept
		err_d = (err_q != ST_OK) ? err_q : err_new;

		// payload window is positions 6 .. 6+size-1
		in_payload = (cnt_q >= HEADER_LEN) &&
			(cnt_q < ({2'b00, size_q} + HEADER_LEN));
		sum_ok = (sum_q == val);

		sum_d  = sum_q;
		type_d = type_q;
		seq_d  = seq_q;
		size_d = size_q;
		cnt_d  = cnt_q;
		if (have) begin
			sum_d = sum_q + val;
			if (cnt_q == POS_TYPE)
				type_d = val;
			else if (cnt_q == POS_SEQ)
				seq_d = val;
			else if (cnt_q < HEADER_LEN)
				size_d = {size_q[23:0], val};
			if (cnt_q != CNT_MAX)
				cnt_d = cnt_q + CNT_W'(1);
		end

		// end-of-message status, in priority order
		if (err_d != ST_OK)
			end_st = err_d;
		else if (cnt_d < MIN_LEN)
			end_st = ST_SHORT;
		else if (cnt_d < ({2'b00, size_d} + MIN_LEN))
			end_st = ST_PAYLOAD_SHORT;
		else if (!have || !sum_ok)
			end_st = ST_CHECKSUM;
		else
			end_st = ST_OK;

		res.msg_type      = type_d;
		res.msg_seq       = seq_d;
		res.declared_size = size_d;
		if (last_s1) begin
			res.valid        = step;
			res.is_status    = 1'b1;
			res.payload_byte = 8'd0;
			res.status       = end_st;
			res.last         = 1'b1;
		end else begin
			res.valid        = step && have && (err_q == ST_OK) && in_payload;
			res.is_status    = 1'b0;
			res.payload_byte = val;
			res.status       = ST_OK;
			res.last         = 1'b0;
		end
	end

	// Message state; cleared after the status item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			cnt_q  <= '0;
			type_q <= '0;
			seq_q  <= '0;
			size_q <= '0;
			sum_q  <= '0;
			err_q  <= ST_OK;
		end else if (step) begin
			if (last_s1) begin
				esc_q  <= 1'b0;
				cnt_q  <= '0;
				type_q <= '0;
				seq_q  <= '0;
				size_q <= '0;
				sum_q  <= '0;
				err_q  <= ST_OK;
			end else begin
				esc_q  <= esc_d;
				cnt_q  <= cnt_d;
				type_q <= type_d;
				seq_q  <= seq_d;
				size_q <= size_d;
				sum_q  <= sum_d;
				err_q  <= err_d;
			end
		end
	end

endmodule

// ----- rtl/efd_out_reg.sv -----
// Result register that holds one item until the output side takes it.
module efd_out_reg import efd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  efd_result_t res,
	output logic        valid,
	output efd_result_t data
);

	logic        valid_q;
	efd_result_t data_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= res.valid;
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (load && res.valid)
			data_q <= res;
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// ----- rtl/escaped_frame_decoder.sv -----
// Top level of the escaped frame decoder: input register, decode core, result register.
// The decoder takes one escaped message byte per cycle and may take a new byte in every
// cycle unless in_stall is high. A byte is captured in the input register when accepted,
// decoded from there by the combinational state update logic (unescape, header capture,
// 8-bit running sum, status), and its payload or status item, if any, is loaded into the
// result register when both stages advance, from where it is offered on out_valid.
// Throughput is one byte per cycle while out_stall does not hold the stages; output stall
// holds both stages and is passed back to in_stall in the same cycle. The byte flagged
// last always yields exactly one status item and clears the message state for the next
// message.
`include "escaped_frame_decoder_defines.svh"

module escaped_frame_decoder import efd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_status,
	output logic [7:0]  payload_byte,
	output logic [7:0]  msg_type,
	output logic [7:0]  msg_seq,
	output logic [31:0] declared_size,
	output logic [2:0]  status,
	output logic        out_last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	logic        accept;
	efd_result_t core_res;
	efd_result_t out_data;

	// Both stages move when the result register is free or being emptied
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	efd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.res     (core_res)
	);

	efd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.res    (core_res),
		.valid  (out_valid),
		.data   (out_data)
	);

	assign is_status     = out_data.is_status;
	assign payload_byte  = out_data.payload_byte;
	assign msg_type      = out_data.msg_type;
	assign msg_seq       = out_data.msg_seq;
	assign declared_size = out_data.declared_size;
	assign status        = out_data.status;
	assign out_last      = out_data.last;

	// Checks
	`EFD_ASSERT_RUN(a_status_item_shape, out_valid && is_status |-> out_last && payload_byte == 8'd0, "status item must carry last and a zero byte")
	`EFD_ASSERT_RUN(a_payload_item_shape, out_valid && !is_status |-> !out_last && status == ST_OK, "payload item must carry ok status and no last")
	`EFD_ASSERT_RUN(a_stall_needs_item, in_stall |-> valid_s1 && out_valid && out_stall, "input stalled without a held item")
	`EFD_ASSERT_ANY(a_reset_idle, !arst_n |=> !out_valid && !in_stall, "outputs active after a reset edge")

endmodule
